@@ hdl/tbad_pkg.sv @@
// ----------------------------------------------------------------------------
// tbad_pkg: shared types and constants of the admission pacer
// Holds field widths, register indexes, fixed-point constants and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package tbad_pkg;

  localparam int TIME_BITS_DEF    = 48;
  localparam int BUSY_WAIT_US_DEF = 10000;

  localparam int RATE_W  = 16;
  localparam int LIMIT_W = 16;
  localparam int PEND_W  = 16;
  localparam int DELAY_W = 20;
  localparam int LEVEL_W = 36;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // One token expressed in micro-tokens.
  localparam logic [DELAY_W-1:0] MICRO = 20'd1000000;

  // Divider: numerator is need + rate - 1, below 2^21.
  localparam int NUM_W = DELAY_W + 1;
  localparam int CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'd1;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  typedef struct packed {
    logic load_in;
    logic refill;
    logic add;
    logic eval;
    logic div_step;
    logic div_fin;
    logic load_out;
  } tbad_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } tbad_sts_t;

endpackage

@@ hdl/tbad_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbad_ctrl: sequencing controller
// Steps one request through refill, add, evaluation, division and output.
// ----------------------------------------------------------------------------
module tbad_ctrl import tbad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tbad_cmd_t cmd,
  input  tbad_sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REFILL = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_REFILL;
        end
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_fin = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hdl/tbad_dpath.sv @@
// ----------------------------------------------------------------------------
// tbad_dpath: bucket datapath
// Holds configuration, bucket state, the refill multiplier, a bit-serial
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module tbad_dpath import tbad_pkg::*; #(
  parameter int TIME_BITS    = TIME_BITS_DEF,
  parameter int BUSY_WAIT_US = BUSY_WAIT_US_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_operation,
  input  logic [TIME_BITS-1:0] in_now_us,
  input  logic [PEND_W-1:0]    in_pending_count,
  output logic [DELAY_W-1:0]   out_delay_us,
  input  tbad_cmd_t            cmd,
  output tbad_sts_t            sts
);

  localparam logic [DELAY_W-1:0] BUSY_WAIT = DELAY_W'(BUSY_WAIT_US);
  localparam logic [CNT_W-1:0]   DIV_STEPS = CNT_W'(NUM_W);

  logic [RATE_W-1:0]    rate_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [LEVEL_W-1:0]   cap_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [TIME_BITS-1:0] last_r;
  logic                 seen_r;
  logic                 op_r;
  logic [TIME_BITS-1:0] now_r;
  logic [PEND_W-1:0]    pend_r;
  logic [LEVEL_W-1:0]   prod_r;
  logic                 add_r;
  logic                 busy_r;
  logic [RATE_W-1:0]    rem_r;
  logic [NUM_W-1:0]     quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DELAY_W-1:0]   res_r;
  logic [DELAY_W-1:0]   out_r;

  logic [RATE_W-1:0]    cfg_rate;
  logic [LEVEL_W-1:0]   cfg_cap;
  logic [TIME_BITS-1:0] elapsed;
  logic [LEVEL_W:0]     sum;
  logic                 level_low;
  logic [DELAY_W-1:0]   need;
  logic [NUM_W-1:0]     num;
  logic [RATE_W:0]      shifted;
  logic [RATE_W:0]      trial;
  logic [DELAY_W-1:0]   quo_res;

  // A rate of zero behaves as one.
  assign cfg_rate  = (cfg_wdata == '0) ? RATE_W'(1) : cfg_wdata;
  assign cfg_cap   = LEVEL_W'(cfg_rate) * LEVEL_W'(MICRO);
  assign elapsed   = now_r - last_r;
  assign sum       = {1'b0, level_r} + {1'b0, prod_r};
  assign level_low = level_r < LEVEL_W'(MICRO);
  assign need      = MICRO - level_r[DELAY_W-1:0];
  assign num       = {1'b0, need} + NUM_W'(rate_r) - NUM_W'(1);
  assign shifted   = {rem_r, quo_r[NUM_W-1]};
  assign trial     = shifted - {1'b0, rate_r};
  assign quo_res   = quo_r[DELAY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_W'(1);
      limit_r <= LIMIT_W'(64);
      cap_r   <= LEVEL_W'(MICRO);
      level_r <= LEVEL_W'(MICRO);
      last_r  <= '0;
      seen_r  <= 1'b0;
      add_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RATE: begin
            rate_r  <= cfg_rate;
            cap_r   <= cfg_cap;
            level_r <= cfg_cap;
          end
          REG_LIMIT: begin
            limit_r <= (cfg_wdata == '0) ? LIMIT_W'(1) : cfg_wdata;
          end
          default: ;
        endcase
      end
      if (cmd.refill) begin
        add_r <= 1'b0;
        if (!seen_r) begin
          last_r <= now_r;
          seen_r <= 1'b1;
        end else if (now_r > last_r) begin
          last_r <= now_r;
          if (elapsed >= TIME_BITS'(MICRO)) begin
            level_r <= cap_r;
          end else begin
            add_r <= 1'b1;
          end
        end
      end
      if (cmd.add && add_r) begin
        level_r <= (sum > {1'b0, cap_r}) ? cap_r : sum[LEVEL_W-1:0];
      end
      if (cmd.eval) begin
        if (op_r == OP_RECORD) begin
          level_r <= level_low ? '0 : level_r - LEVEL_W'(MICRO);
        end else if (level_low) begin
          cnt_r <= DIV_STEPS;
        end
      end
      if (cmd.div_step) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_operation;
      now_r  <= in_now_us;
      pend_r <= in_pending_count;
    end
    if (cmd.refill) begin
      prod_r <= LEVEL_W'(elapsed[DELAY_W-1:0]) * LEVEL_W'(rate_r);
    end
    if (cmd.eval) begin
      busy_r <= (op_r == OP_QUERY) && (pend_r >= limit_r);
      rem_r  <= '0;
      quo_r  <= num;
      if (op_r == OP_RECORD) begin
        res_r <= '0;
      end else begin
        res_r <= (pend_r >= limit_r) ? BUSY_WAIT : '0;
      end
    end
    if (cmd.div_step) begin
      if (!trial[RATE_W]) begin
        rem_r <= trial[RATE_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[RATE_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.div_fin) begin
      res_r <= (busy_r && (BUSY_WAIT > quo_res)) ? BUSY_WAIT : quo_res;
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign sts.need_div  = (op_r == OP_QUERY) && level_low;
  assign sts.div_done  = (cnt_r == '0);
  assign out_delay_us  = out_r;

endmodule

@@ hdl/token_bucket_admission_delay.sv @@
// ----------------------------------------------------------------------------
// token_bucket_admission_delay: token-bucket admission pacer
// Answers accept-delay queries and records accepts against a bucket kept in
// micro-tokens, refilled from microsecond timestamps.
// ----------------------------------------------------------------------------
// Sequence: a taken request passes through the refill, add and evaluation
// steps, and the division step when the one-token wait must be divided out;
// the 21-step bit-serial divider and its closing step run there. The result
// is loaded once any earlier result is taken; one request at a time.
// Reset (synchronous, rst_n low): rate 1, pending limit 64, bucket full,
// no time latched, no result pending.
// ----------------------------------------------------------------------------
module token_bucket_admission_delay import tbad_pkg::*; #(
  parameter int TIME_BITS    = TIME_BITS_DEF,
  parameter int BUSY_WAIT_US = BUSY_WAIT_US_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [TIME_BITS-1:0] in_now_us,
  input  logic [PEND_W-1:0]    in_pending_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DELAY_W-1:0]   out_delay_us
);

  // The controller walks each request through its steps; the datapath holds
  // all numeric state. They talk only through the command and status bundles.
  tbad_cmd_t cmd;
  tbad_sts_t sts;

  // The controller owns the output valid flag. The result sits in its own
  // register, so a new request can be taken and worked on while an earlier
  // result still waits for the consumer.
  tbad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath refills the bucket with a registered elapsed-times-rate
  // product, caps it at the full bucket, and for a query that finds less
  // than one token divides the shortfall by the rate, rounding up.
  tbad_dpath #(
    .TIME_BITS    (TIME_BITS),
    .BUSY_WAIT_US (BUSY_WAIT_US)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_operation     (in_operation),
    .in_now_us        (in_now_us),
    .in_pending_count (in_pending_count),
    .out_delay_us     (out_delay_us),
    .cmd              (cmd),
    .sts              (sts)
  );

  // Once a request is taken, intake stays closed on the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another was in flight");

  // Loading the output register always raises the output valid flag.
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

  // The divider is only stepped while it still has steps to run.
  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !sts.div_done)
    else $error("divider stepped past its last step");

  // No delay can exceed MICRO microseconds, the time to refill one token at rate one.
  a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_delay_us <= MICRO))
    else $error("delay out of range");

endmodule
